// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the cartridge bank mapper.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also evaluated while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cbm_pkg.sv =====
// Package for the cartridge bank mapper: request/result types, codes and constants.
// No dependencies; every other RTL file except the assertion header imports it.
package cbm_pkg;

  // Prescaler reload value and prescaler width (signed; the prescaler stays within 0..period).
  localparam int PRESCALE_PERIOD = 341;
  localparam int PRE_W = 10;

  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_CPU_LOOKUP = 2'd2,
    CMD_CHR_LOOKUP = 2'd3
  } cmd_e;

  localparam logic [1:0] REGION_ROM      = 2'd0;
  localparam logic [1:0] REGION_WRAM     = 2'd1;
  localparam logic [1:0] REGION_UNMAPPED = 2'd2;

  localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_SINGLE_A   = 2'd2;
  localparam logic [1:0] MIRROR_SINGLE_B   = 2'd3;

  // Register areas selected by address bits 14:12 of a write at 0x8000 and up.
  localparam logic [2:0] AREA_PRG01 = 3'd0;
  localparam logic [2:0] AREA_PRG2  = 3'd1;
  localparam logic [2:0] AREA_CHR_LO = 3'd2;
  localparam logic [2:0] AREA_CHR_HI = 3'd5;
  localparam logic [2:0] AREA_MISC  = 3'd6;
  localparam logic [2:0] AREA_IRQ   = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INDEX_SELECT_MASK = 3'd0;
  localparam logic [2:0] CFG_PRG_AND_MASK      = 3'd1;
  localparam logic [2:0] CFG_PRG_OR_BITS       = 3'd2;
  localparam logic [2:0] CFG_CHR_AND_MASK      = 3'd3;
  localparam logic [2:0] CFG_CHR_OR_BITS       = 3'd4;
  localparam logic [2:0] CFG_WRAM_PRESENT      = 3'd5;
  localparam logic [2:0] CFG_WRAM_BANK_SEL     = 3'd6;

  localparam int CFG_ADDR_W = 5;

  localparam logic [7:0] PRG0_RESET = 8'h00;
  localparam logic [7:0] PRG1_RESET = 8'h01;
  localparam logic [7:0] PRG2_RESET = 8'hFE;
  localparam logic [7:0] PRG_FIXED  = 8'hFF;
  localparam logic [15:0] CHR_AREA_BASE = 16'hA000;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [1:0] region;
    logic [7:0] bank;
    logic       wram_access;
    logic [7:0] open_bus_byte;
    logic [1:0] mirroring;
    logic       irq_out;
  } result_t;

  typedef struct packed {
    logic [7:0] index_select_mask;
    logic [7:0] prg_and_mask;
    logic [7:0] prg_or_bits;
    logic [7:0] chr_and_mask;
    logic [7:0] chr_or_bits;
    logic       wram_present;
    logic [7:0] wram_bank_sel;
  } cfg_t;

  // Events passed from the write decoder to the IRQ unit.
  typedef struct packed {
    logic       tick;
    logic       latch_wr;
    logic       mode_wr;
    logic       ack_wr;
    logic [7:0] data;
  } irq_ctl_t;

endpackage

// ===== hw/rtl/cbm_item_if.sv =====
// Channel interfaces for mapper requests and results (valid/ready handshake).
// Depends on cbm_pkg.
interface cbm_item_if;
  import cbm_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cbm_result_if;
  import cbm_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/cbm_cfg.sv =====
// APB-style configuration register file of the bank mapper.
// Depends on cbm_pkg.
module cbm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output cbm_pkg::cfg_t                   cfg
);
  import cbm_pkg::*;

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign index  = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_select_mask <= 8'd16;
      cfg.prg_and_mask      <= 8'hFF;
      cfg.prg_or_bits       <= 8'h00;
      cfg.chr_and_mask      <= 8'hFF;
      cfg.chr_or_bits       <= 8'h00;
      cfg.wram_present      <= 1'b1;
      cfg.wram_bank_sel     <= 8'h00;
    end else if (wr_en) begin
      unique case (index)
        CFG_INDEX_SELECT_MASK: cfg.index_select_mask <= pwdata[7:0];
        CFG_PRG_AND_MASK:      cfg.prg_and_mask      <= pwdata[7:0];
        CFG_PRG_OR_BITS:       cfg.prg_or_bits       <= pwdata[7:0];
        CFG_CHR_AND_MASK:      cfg.chr_and_mask      <= pwdata[7:0];
        CFG_CHR_OR_BITS:       cfg.chr_or_bits       <= pwdata[7:0];
        CFG_WRAM_PRESENT:      cfg.wram_present      <= pwdata[0];
        CFG_WRAM_BANK_SEL:     cfg.wram_bank_sel     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      CFG_INDEX_SELECT_MASK: prdata = {24'd0, cfg.index_select_mask};
      CFG_PRG_AND_MASK:      prdata = {24'd0, cfg.prg_and_mask};
      CFG_PRG_OR_BITS:       prdata = {24'd0, cfg.prg_or_bits};
      CFG_CHR_AND_MASK:      prdata = {24'd0, cfg.chr_and_mask};
      CFG_CHR_OR_BITS:       prdata = {24'd0, cfg.chr_or_bits};
      CFG_WRAM_PRESENT:      prdata = {31'd0, cfg.wram_present};
      CFG_WRAM_BANK_SEL:     prdata = {24'd0, cfg.wram_bank_sel};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/cbm_irq.sv =====
// IRQ latch, mode, 8-bit counter and prescaler of the bank mapper.
// Depends on cbm_pkg; driven by the write decoder in cbm_bank.
module cbm_irq (
  input  logic              clk,
  input  logic              rst,
  input  cbm_pkg::irq_ctl_t ctl,
  output logic              pending,
  output logic              pending_next
);
  import cbm_pkg::*;

  localparam logic signed [PRE_W-1:0] PERIOD = PRE_W'(PRESCALE_PERIOD);
  localparam logic signed [PRE_W-1:0] STEP   = PRE_W'(3);

  logic [7:0]              latch, latch_next;
  logic [2:0]              mode, mode_next;
  logic [7:0]              counter, counter_next;
  logic signed [PRE_W-1:0] prescaler, prescaler_next;
  logic signed [PRE_W-1:0] pre_dec;
  logic [7:0]              count_inc;
  logic                    fire;

  assign pre_dec   = prescaler - STEP;
  assign count_inc = counter + 8'd1;

  always_comb begin
    latch_next     = latch;
    mode_next      = mode;
    counter_next   = counter;
    prescaler_next = prescaler;
    pending_next   = pending;
    fire           = 1'b0;
    if (ctl.latch_wr) begin
      latch_next = ctl.data;
    end
    if (ctl.mode_wr) begin
      mode_next    = ctl.data[2:0];
      pending_next = 1'b0;
      if (ctl.data[1]) begin
        counter_next   = latch;
        prescaler_next = PERIOD;
      end
    end
    if (ctl.ack_wr) begin
      mode_next    = {mode[2], mode[0], mode[0]};
      pending_next = 1'b0;
    end
    if (ctl.tick && mode[1]) begin
      if (mode[2]) begin
        fire = 1'b1;
      end else begin
        fire = (pre_dec <= 0);
        prescaler_next = fire ? pre_dec + PERIOD : pre_dec;
      end
      if (fire) begin
        if (count_inc == 8'd0) begin
          counter_next = latch;
          pending_next = 1'b1;
        end else begin
          counter_next = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch     <= 8'd0;
      mode      <= 3'd0;
      counter   <= 8'd0;
      prescaler <= '0;
      pending   <= 1'b0;
    end else begin
      latch     <= latch_next;
      mode      <= mode_next;
      counter   <= counter_next;
      prescaler <= prescaler_next;
      pending   <= pending_next;
    end
  end

endmodule

// ===== hw/rtl/cbm_bank.sv =====
// Bank registers, write decoder and address lookup of the bank mapper.
// Depends on cbm_pkg; feeds IRQ events to cbm_irq.
module cbm_bank (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cbm_pkg::item_t    item,
  input  cbm_pkg::cfg_t     cfg,
  output cbm_pkg::irq_ctl_t irq_ctl,
  output cbm_pkg::result_t  res
);
  import cbm_pkg::*;

  logic [7:0]  prg [3];
  logic [7:0]  chr [8];
  logic [7:0]  misc, misc_next;
  logic        wr, idx;
  logic [15:0] chr_off;
  logic [2:0]  chr_wsel;
  logic [7:0]  prg_raw;

  assign wr       = en && (item.command == CMD_WRITE) && item.address[15];
  assign idx      = |(item.address[7:0] & cfg.index_select_mask);
  assign chr_off  = item.address - CHR_AREA_BASE;
  assign chr_wsel = {chr_off[13:12], idx};

  always_comb begin
    misc_next        = misc;
    irq_ctl.tick     = en && (item.command == CMD_TICK);
    irq_ctl.latch_wr = 1'b0;
    irq_ctl.mode_wr  = 1'b0;
    irq_ctl.ack_wr   = 1'b0;
    irq_ctl.data     = item.data;
    if (wr && (item.address[14:12] == AREA_MISC)) begin
      if (idx) irq_ctl.latch_wr = 1'b1;
      else     misc_next        = item.data;
    end
    if (wr && (item.address[14:12] == AREA_IRQ)) begin
      irq_ctl.mode_wr = !idx;
      irq_ctl.ack_wr  = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg[0] <= PRG0_RESET;
      prg[1] <= PRG1_RESET;
      prg[2] <= PRG2_RESET;
      for (int i = 0; i < 8; i++) begin
        chr[i] <= 8'(i);
      end
      misc <= 8'd0;
    end else begin
      misc <= misc_next;
      if (wr) begin
        case (item.address[14:12]) inside
          AREA_PRG01: prg[{1'b0, idx}] <= item.data;
          AREA_PRG2: begin
            if (!idx) prg[2] <= item.data;
          end
          [AREA_CHR_LO:AREA_CHR_HI]: chr[chr_wsel] <= item.data;
          default: ;
        endcase
      end
    end
  end

  // The top 8K window always maps the last bank.
  always_comb begin
    if (item.address[14:13] == 2'd3) prg_raw = PRG_FIXED;
    else                             prg_raw = prg[item.address[14:13]];
  end

  always_comb begin
    res.region        = REGION_UNMAPPED;
    res.bank          = 8'd0;
    res.open_bus_byte = 8'd0;
    res.wram_access   = misc_next[7];
    res.irq_out       = 1'b0;
    case (misc_next[1:0])
      2'b00:   res.mirroring = MIRROR_VERTICAL;
      2'b01:   res.mirroring = MIRROR_HORIZONTAL;
      2'b10:   res.mirroring = MIRROR_SINGLE_A;
      default: res.mirroring = MIRROR_SINGLE_B;
    endcase
    case (item.command)
      CMD_CPU_LOOKUP: begin
        if (item.address[15]) begin
          res.region = REGION_ROM;
          res.bank   = (prg_raw & cfg.prg_and_mask) | cfg.prg_or_bits;
        end else if ((item.address[14:13] == 2'd3) && cfg.wram_present) begin
          res.region = REGION_WRAM;
          res.bank   = cfg.wram_bank_sel;
          if (!misc[7]) res.open_bus_byte = item.address[15:8];
        end else begin
          res.open_bus_byte = item.address[15:8];
        end
      end
      CMD_CHR_LOOKUP: begin
        if (item.address[15:13] == 3'd0) begin
          res.region = REGION_ROM;
          res.bank   = (chr[item.address[12:10]] & cfg.chr_and_mask) | cfg.chr_or_bits;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/cartridge_bank_mapper_with_irq.sv =====
// Cartridge bank mapper with a prescaled IRQ counter.
// Pipeline: an accepted request waits in the input register until its result can move into
// the result register, which holds it until accepted. One request per cycle while the result
// side keeps up; the bank decode and IRQ update fit between the two registers.
// Reset (rst, synchronous, active high) restores the bank, misc, IRQ and config registers
// and empties both pipeline registers.
`include "assert_macros.svh"

module cartridge_bank_mapper_with_irq (
  input  logic                           clk,
  input  logic                           rst,
  cbm_item_if.sink                       item,
  cbm_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import cbm_pkg::*;

  // Input register: holds one accepted request until the processing stage
  // can hand its result to the output register.
  logic     in_valid;
  item_t    in_item;
  // Output register: the result waits here for the downstream side.
  logic     out_valid;
  result_t  out_res;

  logic     fire;
  cfg_t     cfg;
  irq_ctl_t irq_ctl;
  result_t  bank_res;
  result_t  res_full;
  logic     irq_pending, irq_pending_next;

  // A request is processed (and its state effects committed) in the cycle it
  // moves from the input register into the output register.
  assign fire       = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item <= item.payload;
    end
  end

  cbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbm_bank u_bank (
    .clk     (clk),
    .rst     (rst),
    .en      (fire),
    .item    (in_item),
    .cfg     (cfg),
    .irq_ctl (irq_ctl),
    .res     (bank_res)
  );

  cbm_irq u_irq (
    .clk          (clk),
    .rst          (rst),
    .ctl          (irq_ctl),
    .pending      (irq_pending),
    .pending_next (irq_pending_next)
  );

  // The IRQ line is reported as it stands after this request.
  always_comb begin
    res_full         = bank_res;
    res_full.irq_out = irq_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_full;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_res;

  // A processed request always leaves a result behind.
  `ASSERT_CLK(a_fire_gives_result, clk, rst, fire |=> out_valid, "processed request lost")
  // The IRQ only rises as a result of a tick request.
  `ASSERT_CLK(a_irq_from_tick, clk, rst,
    $rose(irq_pending) |-> $past(fire && (in_item.command == CMD_TICK)), "IRQ raised without tick")
  // Writes and ticks never report a mapped region.
  `ASSERT_CLK(a_ctl_unmapped, clk, rst,
    (fire && ((in_item.command == CMD_WRITE) || (in_item.command == CMD_TICK))) |=>
    (out_res.region == REGION_UNMAPPED), "write or tick reported a mapped region")

endmodule

// ===== verif/cbm_mapper_checker.sv =====
// Checker for the cartridge bank mapper: watches the request, result and APB channels,
// predicts every result from its own mapper state and compares. Depends on cbm_pkg and
// the channel interfaces in cbm_item_if.sv.
module cbm_mapper_checker (
  input  logic                           clk,
  input  logic                           rst,
  cbm_item_if                            req_ch,
  cbm_result_if                          rsp_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [cbm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             results_due,
  output int                             fault_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbm_pkg::*;

  localparam int REPORT_MAX = 10;

  // Predicted mapper state and the configuration as written over APB.
  cfg_t                    cfg;
  logic [7:0]              prg_sel [3];
  logic [7:0]              chr_sel [8];
  logic [7:0]              misc_byte;
  logic [7:0]              irq_reload;
  logic [2:0]              irq_ctrl;
  logic [7:0]              irq_count;
  logic signed [PRE_W-1:0] pre_count;
  logic                    irq_flag;

  result_t due_q[$];
  int      faults = 0;

  task automatic reset_model();
    cfg.index_select_mask = 8'h10;
    cfg.prg_and_mask      = 8'hFF;
    cfg.prg_or_bits       = 8'h00;
    cfg.chr_and_mask      = 8'hFF;
    cfg.chr_or_bits       = 8'h00;
    cfg.wram_present      = 1'b1;
    cfg.wram_bank_sel     = 8'h00;
    prg_sel[0] = PRG0_RESET;
    prg_sel[1] = PRG1_RESET;
    prg_sel[2] = PRG2_RESET;
    for (int i = 0; i < 8; i++) chr_sel[i] = 8'(i);
    misc_byte  = '0;
    irq_reload = '0;
    irq_ctrl   = '0;
    irq_count  = '0;
    pre_count  = '0;
    irq_flag   = 1'b0;
  endtask

  task automatic report(string msg);
    faults++;
    if (faults <= REPORT_MAX) $display("%s", msg);
  endtask

  // Advances the mapper state by one request and returns the result it produces.
  function automatic result_t apply_request(item_t it);
    result_t    res;
    logic       idx;
    logic       fire;
    logic [15:0] chr_off;
    logic [7:0] raw;
    res = '0;
    res.region = REGION_UNMAPPED;
    fire = 1'b0;
    idx = |(it.address[7:0] & cfg.index_select_mask);
    case (it.command)
      CMD_WRITE: begin
        if (it.address[15]) begin
          case (it.address[14:12])
            AREA_PRG01: prg_sel[{1'b0, idx}] = it.data;
            AREA_PRG2:  if (!idx) prg_sel[2] = it.data;
            AREA_MISC: begin
              if (!idx) misc_byte = it.data;
              else irq_reload = it.data;
            end
            AREA_IRQ: begin
              if (!idx) begin
                irq_ctrl = it.data[2:0];
                if (irq_ctrl[1]) begin
                  irq_count = irq_reload;
                  pre_count = PRE_W'(PRESCALE_PERIOD);
                end
              end else begin
                irq_ctrl = {irq_ctrl[2], irq_ctrl[0], irq_ctrl[0]};
              end
              irq_flag = 1'b0;
            end
            default: begin
              chr_off = it.address - CHR_AREA_BASE;
              chr_sel[{chr_off[13:12], idx}] = it.data;
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (irq_ctrl[1]) begin
          if (irq_ctrl[2]) begin
            fire = 1'b1;
          end else begin
            pre_count = pre_count - 10'sd3;
            fire = (pre_count <= 0);
            if (fire) pre_count = PRE_W'(pre_count + PRESCALE_PERIOD);
          end
          if (fire) begin
            irq_count = irq_count + 8'd1;
            if (irq_count == 8'd0) begin
              irq_count = irq_reload;
              irq_flag = 1'b1;
            end
          end
        end
      end
      CMD_CPU_LOOKUP: begin
        if (it.address[15]) begin
          raw = (it.address[14:13] == 2'd3) ? PRG_FIXED : prg_sel[it.address[14:13]];
          res.region = REGION_ROM;
          res.bank = (raw & cfg.prg_and_mask) | cfg.prg_or_bits;
        end else if (it.address >= 16'h6000 && cfg.wram_present) begin
          res.region = REGION_WRAM;
          res.bank = cfg.wram_bank_sel;
          if (!misc_byte[7]) res.open_bus_byte = it.address[15:8];
        end else begin
          res.open_bus_byte = it.address[15:8];
        end
      end
      default: begin
        if (it.address < 16'h2000) begin
          res.region = REGION_ROM;
          res.bank = (chr_sel[it.address[12:10]] & cfg.chr_and_mask) | cfg.chr_or_bits;
        end
      end
    endcase
    res.wram_access = misc_byte[7];
    case (misc_byte[1:0])
      2'b00:   res.mirroring = MIRROR_VERTICAL;
      2'b01:   res.mirroring = MIRROR_HORIZONTAL;
      2'b10:   res.mirroring = MIRROR_SINGLE_A;
      default: res.mirroring = MIRROR_SINGLE_B;
    endcase
    res.irq_out = irq_flag;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      reset_model();
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          CFG_INDEX_SELECT_MASK: cfg.index_select_mask = pwdata[7:0];
          CFG_PRG_AND_MASK:      cfg.prg_and_mask      = pwdata[7:0];
          CFG_PRG_OR_BITS:       cfg.prg_or_bits       = pwdata[7:0];
          CFG_CHR_AND_MASK:      cfg.chr_and_mask      = pwdata[7:0];
          CFG_CHR_OR_BITS:       cfg.chr_or_bits       = pwdata[7:0];
          CFG_WRAM_PRESENT:      cfg.wram_present      = pwdata[0];
          CFG_WRAM_BANK_SEL:     cfg.wram_bank_sel     = pwdata[7:0];
          default: ;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (due_q.size() == 0) begin
          report($sformatf("unexpected result at %0t: region=%0d bank=%02h", $realtime,
                           got.region, got.bank));
        end else begin
          want = due_q.pop_front();
          if (got !== want)
            report($sformatf({"result mismatch at %0t: expected region=%0d bank=%02h ",
                              "wram=%0b obus=%02h mirror=%0d irq=%0b, got region=%0d ",
                              "bank=%02h wram=%0b obus=%02h mirror=%0d irq=%0b"},
                             $realtime, want.region, want.bank, want.wram_access,
                             want.open_bus_byte, want.mirroring, want.irq_out,
                             got.region, got.bank, got.wram_access, got.open_bus_byte,
                             got.mirroring, got.irq_out));
        end
      end
      if (req_ch.valid && req_ch.ready) due_q.push_back(apply_request(req_ch.payload));
    end
    results_due <= due_q.size();
    fault_count <= faults;
  end

endmodule

// ===== verif/tb.sv =====
// Top of the mapper testbench: clock, reset, request stimulus, result back-pressure,
// APB configuration and the verdict. Depends on cbm_pkg, the channel interfaces,
// cbm_mapper_checker and the cartridge_bank_mapper_with_irq RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbm_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 205;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  cbm_item_if   req_ch();
  cbm_result_if rsp_ch();

  int results_due;
  int fault_count;

  // Stimulus bookkeeping. cur_cfg mirrors what has been written over APB so that
  // register writes can be aimed at index 0 or index 1 on purpose.
  cfg_t cur_cfg = '{index_select_mask: 8'h10, prg_and_mask: 8'hFF, prg_or_bits: 8'h00,
                    chr_and_mask: 8'hFF, chr_or_bits: 8'h00, wram_present: 1'b1,
                    wram_bank_sel: 8'h00};
  int sent       = 0;
  int tx_gap_max = 8;
  int rx_count   = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  cartridge_bank_mapper_with_irq u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (req_ch),
    .result  (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cbm_mapper_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_ch      (req_ch),
    .rsp_ch      (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .results_due (results_due),
    .fault_count (fault_count)
  );

  // Offers one request. Valid stays high between back-to-back requests; it only
  // drops when the drawn gap is non-zero, so it never toggles within one step.
  task automatic send(cmd_e c, logic [15:0] a, logic [7:0] d);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= {c, a, d};
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Builds a register address in the given area whose index-select bits pick
  // index 0 or 1 under the current mask. With a zero mask only index 0 exists.
  function automatic logic [15:0] reg_addr(logic [2:0] area, logic idx);
    logic [31:0] r;
    logic [15:0] a;
    r = $urandom;
    a = {1'b1, area, r[11:0]};
    if (!idx) a[7:0] = a[7:0] & ~cur_cfg.index_select_mask;
    else if ((a[7:0] & cur_cfg.index_select_mask) == 8'h00)
      a[7:0] = a[7:0] | cur_cfg.index_select_mask;
    return a;
  endfunction

  // CPU or character lookup, weighted toward the interesting windows: program
  // ROM and work RAM for the CPU side, the pattern area for the character side.
  task automatic rand_lookup();
    logic [31:0] r;
    r = $urandom;
    if (r[0]) begin
      case (r[2:1])
        2'd0, 2'd1: send(CMD_CPU_LOOKUP, {1'b1, r[30:16]}, r[15:8]);
        2'd2:       send(CMD_CPU_LOOKUP, {3'b011, r[28:16]}, r[15:8]);
        default:    send(CMD_CPU_LOOKUP, r[31:16], r[15:8]);
      endcase
    end else begin
      if (r[2:1] != 2'd3) send(CMD_CHR_LOOKUP, {3'b000, r[28:16]}, r[15:8]);
      else send(CMD_CHR_LOOKUP, r[31:16], r[15:8]);
    end
  endtask

  // One random request: mostly register writes, ticks and lookups, with some
  // fully random noise (writes below 0x8000, odd commands and addresses).
  task automatic rand_request();
    int pick;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    r = $urandom;
    if (pick < 30) send(CMD_WRITE, reg_addr(r[2:0], r[3]), r[15:8]);
    else if (pick < 55) send(CMD_TICK, r[15:0], r[23:16]);
    else if (pick < 85) rand_lookup();
    else send(cmd_e'(r[1:0]), r[31:16], r[9:2]);
  endtask

  // A well-formed IRQ sequence: load the latch close to overflow, arm the counter,
  // then send a run of ticks that may or may not wrap it. The slow variant runs
  // through the prescaler, which takes over a hundred ticks per count; the fast one
  // counts every tick. Lookups are sprinkled in, and the IRQ is acknowledged half the time.
  task automatic irq_burst();
    logic [31:0] r;
    logic        slow;
    logic [7:0]  latch;
    int          ticks;
    r = $urandom;
    slow = (r[1:0] == 2'd0);
    latch = slow ? 8'hFF : {4'hF, r[7:4]};
    ticks = slow ? $urandom_range(110, 125) : $urandom_range(4, 24);
    send(CMD_WRITE, reg_addr(AREA_MISC, 1'b1), latch);
    send(CMD_WRITE, reg_addr(AREA_IRQ, 1'b0), {5'b00000, ~slow, 1'b1, r[8]});
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 7) == 0) rand_lookup();
      else send(CMD_TICK, r[31:16], r[23:16]);
    end
    if (r[9]) send(CMD_WRITE, reg_addr(AREA_IRQ, 1'b1), r[31:24]);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Drains the block, then rewrites every configuration register. Every request
  // yields exactly one result, so an empty result queue means the pipe is idle;
  // an extra wait after that covers the two pipeline stages anyway.
  task automatic reconfigure(cfg_t c);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
    apb_write(CFG_INDEX_SELECT_MASK, {24'h0, c.index_select_mask});
    apb_write(CFG_PRG_AND_MASK,      {24'h0, c.prg_and_mask});
    apb_write(CFG_PRG_OR_BITS,       {24'h0, c.prg_or_bits});
    apb_write(CFG_CHR_AND_MASK,      {24'h0, c.chr_and_mask});
    apb_write(CFG_CHR_OR_BITS,       {24'h0, c.chr_or_bits});
    apb_write(CFG_WRAM_PRESENT,      {31'h0, c.wram_present});
    apb_write(CFG_WRAM_BANK_SEL,     {24'h0, c.wram_bank_sel});
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = c;
  endtask

  // Result side. Ready is withdrawn for a random gap, which may be empty, before
  // each result, except in alternating stretches of 160 results where it stays high.
  // Once, in the middle of the run, ready is held low for a long stretch while
  // requests keep coming, so the pipe fills and the block pushes back on its input.
  initial begin
    int  gap;
    bit  held_off;
    held_off = 1'b0;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_count == HOLD_AT && !held_off) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = ((rx_count / 160) % 2 == 1) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      rx_count++;
    end
  end

  // Watchdog: any accepted request, result or APB access counts as progress.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    logic [31:0] r;
    logic [31:0] s;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset configuration (index bit is address bit 4).
    // Reset bank layout first: the three switchable program slots, the fixed
    // last bank, work RAM with open bus, the unmapped low area, and character
    // lookups inside and above the pattern area.
    send(CMD_CPU_LOOKUP, 16'h8000, 8'h00);
    send(CMD_CPU_LOOKUP, 16'hA123, 8'h00);
    send(CMD_CPU_LOOKUP, 16'hC000, 8'h00);
    send(CMD_CPU_LOOKUP, 16'hFFFF, 8'hFF);
    send(CMD_CPU_LOOKUP, 16'h6000, 8'h00);
    send(CMD_CPU_LOOKUP, 16'h5FFF, 8'h00);
    send(CMD_CHR_LOOKUP, 16'h0000, 8'h00);
    send(CMD_CHR_LOOKUP, 16'h1FFF, 8'h00);
    send(CMD_CHR_LOOKUP, 16'h2000, 8'h00);
    // Bank writes, including the ignored index-1 write in the second program
    // area and a write below 0x8000 that must change nothing.
    send(CMD_WRITE, 16'h8000, 8'hFF);
    send(CMD_WRITE, 16'h8010, 8'h80);
    send(CMD_WRITE, 16'h9000, 8'h3C);
    send(CMD_WRITE, 16'h9010, 8'h55);
    send(CMD_WRITE, 16'hDFFF, 8'hA5);
    send(CMD_WRITE, 16'hA000, 8'h00);
    send(CMD_WRITE, 16'h7FFF, 8'h12);
    // Misc write: single-screen B mirroring and work RAM access on.
    send(CMD_WRITE, 16'hE000, 8'h83);
    // Latch 0xFE, cycle mode armed: two ticks wrap the counter and raise the IRQ.
    send(CMD_WRITE, 16'hE010, 8'hFE);
    send(CMD_WRITE, 16'hF000, 8'h06);
    send(CMD_TICK,  16'h0000, 8'h00);
    send(CMD_TICK,  16'hFFFF, 8'hFF);
    send(CMD_CPU_LOOKUP, 16'h6ABC, 8'h00);
    // Acknowledge: clears the IRQ and copies mode bit 0 (clear) into bit 1.
    send(CMD_WRITE, 16'hF010, 8'h00);
    send(CMD_CPU_LOOKUP, 16'h8000, 8'h00);
    send(CMD_CHR_LOOKUP, 16'h1C00, 8'h00);
    // Prescaled mode with bit 0 set, a couple of ticks through the prescaler.
    send(CMD_WRITE, 16'hF000, 8'h03);
    send(CMD_TICK,  16'h1234, 8'h56);
    send(CMD_TICK,  16'hEDCB, 8'hA9);

    // Random phases. The first restores the reset configuration explicitly, the
    // next two drive every register to its lowest and highest values, and the
    // rest use random settings. Odd phases send requests back to back.
    for (int ph = 0; ph < PHASES; ph++) begin
      r = $urandom;
      s = $urandom;
      case (ph)
        0: c = '{index_select_mask: 8'h10, prg_and_mask: 8'hFF, prg_or_bits: 8'h00,
                 chr_and_mask: 8'hFF, chr_or_bits: 8'h00, wram_present: 1'b1,
                 wram_bank_sel: 8'h00};
        1: c = '0;
        2: c = '1;
        default: begin
          c.index_select_mask = (r[7:0] == 8'h00) ? 8'h40 : r[7:0];
          c.prg_and_mask      = r[15:8];
          c.prg_or_bits       = r[23:16];
          c.chr_and_mask      = r[31:24];
          c.chr_or_bits       = s[7:0];
          c.wram_present      = s[8];
          c.wram_bank_sel     = s[23:16];
        end
      endcase
      reconfigure(c);
      tx_gap_max = (ph % 2 == 1) ? 0 : 8;
      while (sent < 30 + (ph + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 6) irq_burst();
        else rand_request();
      end
    end

    // Let every outstanding result come back, then keep watching in case
    // the block emits something it should not.
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
    if (fault_count == 0 && results_due == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_item_if.sv
hw/rtl/cbm_cfg.sv
hw/rtl/cbm_irq.sv
hw/rtl/cbm_bank.sv
hw/rtl/cartridge_bank_mapper_with_irq.sv
verif/cbm_mapper_checker.sv
verif/tb.sv
